### hw/rtl/slipcrc_pkg.sv
// Shared types, protocol constants and the byte-wide CRC-32 update for the
// SLIP frame decoder. No dependencies.
`timescale 1ns / 1ps

package slipcrc_pkg;

   localparam logic [7:0]  BYTE_END     = 8'hC0;
   localparam logic [7:0]  BYTE_ESC     = 8'hDB;
   localparam logic [7:0]  BYTE_ESC_END = 8'hDC;
   localparam logic [7:0]  BYTE_ESC_ESC = 8'hDD;

   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

   localparam int          LEN_W        = 11;
   localparam logic [LEN_W-1:0] LEN_CAP   = 11'd1024;
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd128;
   localparam logic [LEN_W-1:0] LEN_MIN   = 11'd5;
   localparam logic [LEN_W-1:0] WIN_DEPTH = 11'd4;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_BAD_CRC  = 2'd1,
      ST_SHORT    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        body;
      status_type        status;
      logic [LEN_W-1:0]  length;
   } result_type;

   // Reflected CRC-32 fold of one byte, LSB first.
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] v);
      logic [31:0] c;
      c = crc ^ {24'd0, v};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hw/rtl/slipcrc_core.sv
// Frame state of the SLIP decoder: unescape, length check, delay window, CRC.
// Depends on slipcrc_pkg.
`timescale 1ns / 1ps

module slipcrc_core
   import slipcrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,        // consume line_byte this cycle
   input  logic [7:0]       line_byte,
   input  logic [LEN_W-1:0] limit,
   output logic             has_result,  // line_byte gives a result word
   output result_type       result
);

   logic             esc_ff,   esc_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [7:0]       win_ff [4];
   logic [7:0]       win_in [4];
   logic [31:0]      crc_ff,   crc_in;

   logic [7:0]  byte_dec;
   logic [31:0] want;

   assign want = {win_ff[3], win_ff[2], win_ff[1], win_ff[0]};

   always_comb begin
      esc_in     = esc_ff;
      count_in   = count_ff;
      win_in     = win_ff;
      crc_in     = crc_ff;
      has_result = 1'b0;
      result     = '{kind: KIND_DATA, body: 8'd0, status: ST_GOOD, length: '0};

      byte_dec = line_byte;
      if (esc_ff) begin
         if (line_byte == BYTE_ESC_END) begin
            byte_dec = BYTE_END;
         end else if (line_byte == BYTE_ESC_ESC) begin
            byte_dec = BYTE_ESC;
         end
      end

      if (line_byte == BYTE_END) begin
         // end of frame; an open escape is dropped
         if (count_ff != '0) begin
            has_result    = 1'b1;
            result.kind   = KIND_STATUS;
            result.length = count_ff;
            if (count_ff < LEN_MIN) begin
               result.status = ST_SHORT;
            end else if (~crc_ff == want) begin
               result.status = ST_GOOD;
            end else begin
               result.status = ST_BAD_CRC;
            end
         end
         esc_in   = 1'b0;
         count_in = '0;
         win_in   = '{default: 8'd0};
         crc_in   = CRC_INIT;
      end else if (!esc_ff && line_byte == BYTE_ESC) begin
         esc_in = 1'b1;
      end else if (count_ff >= limit) begin
         // frame full: drop byte, report, restart
         has_result    = 1'b1;
         result.kind   = KIND_STATUS;
         result.status = ST_OVERFLOW;
         result.length = count_ff;
         esc_in   = 1'b0;
         count_in = '0;
         win_in   = '{default: 8'd0};
         crc_in   = CRC_INIT;
      end else if (count_ff < WIN_DEPTH) begin
         esc_in                 = 1'b0;
         win_in[count_ff[1:0]]  = byte_dec;
         count_in               = count_ff + 1'b1;
      end else begin
         // oldest window byte leaves as body data
         esc_in      = 1'b0;
         has_result  = 1'b1;
         result.body = win_ff[0];
         crc_in      = crc_fold(crc_ff, win_ff[0]);
         win_in[0]   = win_ff[1];
         win_in[1]   = win_ff[2];
         win_in[2]   = win_ff[3];
         win_in[3]   = byte_dec;
         count_in    = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         count_ff <= '0;
         win_ff   <= '{default: 8'd0};
         crc_ff   <= CRC_INIT;
      end else if (step) begin
         esc_ff   <= esc_in;
         count_ff <= count_in;
         win_ff   <= win_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

### hw/rtl/slip_crc32_frame_decoder.sv
// Top level of the SLIP deframer with CRC-32 check: handshakes, limit register
// and the input and result registers around slipcrc_core.
// Depends on slipcrc_pkg and slipcrc_core.
`timescale 1ns / 1ps

// Usage
//   req_*  : raw serial-line bytes, one word per valid/ready handshake.
//   rsp_*  : result words. result_kind 0 carries an unescaped body byte in
//            body_byte; result_kind 1 carries frame_status and frame_length.
//            Body bytes are tentative: drop the frame's bytes unless the
//            status word that follows reports good.
//   csr_*  : writes max_frame_len (above 1024 acts as 1024). csr_ready is
//            always high; write only while the block is idle.
// Path: an accepted byte lands in the input register; its result word, if any,
//   then moves to the result register and is presented from there.
// Throughput: one byte per cycle unless a stall holds the result register. The
//   whole per-byte update (unescape, window shift, byte-wide CRC fold) sits
//   between the input register and the result register.
// Reset: frame state clears, CRC returns to all ones, limit returns to 128,
//   both registers empty.
// Stall: while rsp_ready is low a held result stays put. Bytes that give no
//   result still go through; a byte that would give one waits in the input
//   register and req_ready drops.

module slip_crc32_frame_decoder
   import slipcrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_line_byte,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_body_byte,
   output logic [1:0]       rsp_frame_status,
   output logic [LEN_W-1:0] rsp_frame_length,

   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_max_frame_len
);

   // limit register
   logic [LEN_W-1:0] max_len_ff;
   logic [LEN_W-1:0] limit;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       has_result;
   result_type result;
   logic       advance;   // input register word is processed this cycle

   assign csr_ready = 1'b1;
   assign limit     = (max_len_ff > LEN_CAP) ? LEN_CAP : max_len_ff;

   // A word with no result never needs the result register.
   assign advance   = in_valid_ff && (!has_result || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && has_result) || (out_valid_ff && !rsp_ready);

   slipcrc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .line_byte  (in_byte_ff),
      .limit      (limit),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= LEN_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_frame_len;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_line_byte;
      end
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_ff.kind;
   assign rsp_body_byte    = out_ff.body;
   assign rsp_frame_status = out_ff.status;
   assign rsp_frame_length = out_ff.length;

`ifndef ASSERT_OFF
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_ff.kind == KIND_DATA |-> out_ff.status == ST_GOOD && out_ff.length == '0)
      else $error("data word carries status or length");

   // overflow at a zero limit reports an empty frame
   a_status_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_ff.kind == KIND_STATUS |->
         (out_ff.length != '0 || out_ff.status == ST_OVERFLOW) && out_ff.length <= LEN_CAP)
      else $error("status word length out of range");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_ff.kind == KIND_STATUS && out_ff.status == ST_SHORT |->
         out_ff.length < LEN_MIN)
      else $error("short status on a frame of full length");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !(advance && has_result))
      else $error("result register overwritten while stalled");
`endif

endmodule
